// ===== rtl/pdad_pkg.sv =====
// Package for the PWM duty-cycle position decoder.
// Holds shared constants, register indexes and the state types.
// No dependencies.
package pdad_pkg;

    // Defaults for the top-level parameters
    localparam int TIMESTAMP_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF   = 4;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS     = 2'd2;

    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd16448;
    localparam logic [CFG_W-1:0] OFFSET_RST     = 16'd32;
    localparam logic [CFG_W-1:0] COUNTS_RST     = 16'd16384;

    // Result fields
    localparam int POS_W      = 20;
    localparam int TICKS_W    = 32;
    localparam int OUT_BITS   = POS_W + 2 * TICKS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_MAX = 20'hFFFFF;

    // Top-level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_HOLD
    } dec_state_t;

    // Multiply-divide sequencer
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_DBL,
        MD_ADD
    } md_state_t;

endpackage

// ===== rtl/pwm_duty_angle_decoder_top.sv =====
// Top level of the PWM duty-cycle position decoder.
// Edge tracking, configuration registers, result register.
// Depends on pdad_pkg and pdad_muldiv.
//
//  Channel | Direction | Transfer                          | Contents
//  s_      | in        | s_tvalid & s_tready               | edge kind, timestamp
//  m_      | out       | m_tvalid & m_tready               | position, high, period
//  cfg_    | in        | cfg_wr_en                         | register index, value
//
// A rising edge only updates the edge tracking. A measured falling edge
// starts the multiply-divide: a doubling step and an add step per multiplier
// bit on the shared modular adder, a registered done flag, then the load of
// the result. s_tready is low during that time and while a finished result
// waits for a full output register. Reset is synchronous, active low.
module pwm_duty_angle_decoder_top #(
    parameter int TIMESTAMP_WIDTH = pdad_pkg::TIMESTAMP_WIDTH_DEF,
    parameter int FRACTION_BITS   = pdad_pkg::FRACTION_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input edges
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((TIMESTAMP_WIDTH+7)/8)*8-1:0]     s_tdata,  // [TW-1:0] timestamp
    input  logic                                     s_tuser,  // kind: 1 rising, 0 falling
    // results
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [pdad_pkg::OUT_DATA_W-1:0]          m_tdata,  // position, high, period
    // configuration
    input  logic                                     cfg_wr_en,
    input  logic [pdad_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pdad_pkg::CFG_W-1:0]               cfg_wdata
);
    import pdad_pkg::*;

    localparam int TW    = TIMESTAMP_WIDTH;
    localparam int MW    = CFG_W + FRACTION_BITS;
    localparam int CW    = (MW > POS_W) ? MW : POS_W;
    localparam int PAD_W = OUT_DATA_W - OUT_BITS;

    dec_state_t      state_reg, state_next;

    logic [CFG_W-1:0] full_scale_reg;
    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] counts_reg;

    logic [TW-1:0]   last_rise_reg;
    logic [TW-1:0]   period_reg;
    logic            seen_rise_reg;
    logic [TW-1:0]   high_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [TW-1:0]   ts;
    logic [TW-1:0]   diff;
    logic            in_xfer;
    logic            measure_ok;
    logic            md_start;
    logic            md_done;
    logic [MW-1:0]   md_quot;
    logic            out_free;
    logic            load_out;

    logic [MW-1:0]   mult;
    logic [MW-1:0]   base;
    logic [MW-1:0]   top_v;
    logic [MW-1:0]   pos_sub;
    logic [MW-1:0]   pos_clamp;
    logic [CW-1:0]   pos_ext;
    logic [POS_W-1:0] pos;
    logic [TW+TICKS_W-1:0] high_ext;
    logic [TW+TICKS_W-1:0] period_ext;

    // Edge decode
    assign ts         = s_tdata[TW-1:0];
    assign diff       = ts - last_rise_reg;
    assign in_xfer    = s_tvalid && s_tready;
    assign measure_ok = !s_tuser && seen_rise_reg && (period_reg != '0)
                        && (diff <= period_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer && measure_ok) state_next = ST_CALC;
            ST_CALC: if (md_done) state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready = 1'b0;
        md_start = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                md_start = in_xfer && measure_ok;
            end
            ST_CALC: load_out = md_done && out_free;
            ST_HOLD: load_out = out_free;
            default: ;
        endcase
    end

    // State, edge tracking and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_rise_reg  <= '0;
            period_reg     <= '0;
            seen_rise_reg  <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
            offset_reg     <= OFFSET_RST;
            counts_reg     <= COUNTS_RST;
        end else begin
            state_reg <= state_next;
            if (in_xfer && s_tuser) begin
                if (seen_rise_reg) period_reg <= diff;
                last_rise_reg <= ts;
                seen_rise_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                    REG_OFFSET:     offset_reg     <= cfg_wdata;
                    REG_COUNTS:     counts_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // High time held for the result
    always_ff @(posedge aclk) begin
        if (md_start) high_reg <= diff;
    end

    assign mult = MW'(full_scale_reg) << FRACTION_BITS;

    pdad_muldiv #(.TW(TW), .MW(MW)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .mult    (mult),
        .num     (diff),
        .den     (period_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    // Offset, clamp to one turn, saturate to the field
    assign base      = MW'(offset_reg) << FRACTION_BITS;
    assign top_v     = MW'(counts_reg) << FRACTION_BITS;
    assign pos_sub   = (md_quot > base) ? (md_quot - base) : '0;
    assign pos_clamp = (pos_sub > top_v) ? top_v : pos_sub;
    assign pos_ext   = CW'(pos_clamp);
    assign pos       = (pos_ext > CW'(POS_MAX)) ? POS_MAX : pos_ext[POS_W-1:0];

    assign high_ext   = {{TICKS_W{1'b0}}, high_reg};
    assign period_ext = {{TICKS_W{1'b0}}, period_reg};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, period_ext[TICKS_W-1:0],
                            high_ext[TICKS_W-1:0], pos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/pdad_modadd.sv =====
// Shared modular add/compare unit of the multiply-divide.
// Computes (r + a) mod den for r < den, a <= den, and flags the wrap.
// Uses pdad_pkg only for house consistency of widths.
module pdad_modadd #(
    parameter int TW = pdad_pkg::TIMESTAMP_WIDTH_DEF
) (
    input  logic [TW-1:0] r_in,
    input  logic [TW-1:0] addend,
    input  logic [TW-1:0] den,
    output logic [TW-1:0] r_out,
    output logic          wrap
);
    import pdad_pkg::*;

    logic [TW:0] sum;
    logic [TW:0] diff;

    // One wide add, then compare against the divisor
    assign sum   = {1'b0, r_in} + {1'b0, addend};
    assign diff  = sum - {1'b0, den};
    assign wrap  = (sum >= {1'b0, den});
    assign r_out = wrap ? diff[TW-1:0] : sum[TW-1:0];

endmodule

// ===== rtl/pdad_muldiv.sv =====
// Serial multiply-divide: q = floor(mult * num / den), num <= den, den != 0.
// A doubling step and an add step per multiplier bit on the shared pdad_modadd unit.
// Depends on pdad_pkg and pdad_modadd.
module pdad_muldiv #(
    parameter int TW = pdad_pkg::TIMESTAMP_WIDTH_DEF,
    parameter int MW = pdad_pkg::CFG_W + pdad_pkg::FRACTION_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] mult,
    input  logic [TW-1:0] num,
    input  logic [TW-1:0] den,
    output logic          done,
    output logic [MW-1:0] quot
);
    import pdad_pkg::*;

    localparam int CNT_W = $clog2(MW);

    md_state_t        state_reg, state_next;
    logic [TW-1:0]    r_reg;
    logic [MW-1:0]    q_reg;
    logic [MW-1:0]    mult_reg;
    logic [TW-1:0]    num_reg;
    logic [TW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [TW-1:0]    addend;
    logic [TW-1:0]    r_res;
    logic             wrap;
    logic             last_step;

    // Shared unit: doubling step adds r to itself, add step adds num
    assign addend = (state_reg == MD_DBL) ? r_reg : num_reg;

    pdad_modadd #(.TW(TW)) u_modadd (
        .r_in   (r_reg),
        .addend (addend),
        .den    (den_reg),
        .r_out  (r_res),
        .wrap   (wrap)
    );

    assign last_step = (state_reg == MD_ADD) && (cnt_reg == '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (start) state_next = MD_DBL;
            MD_DBL:  state_next = MD_ADD;
            MD_ADD:  state_next = (cnt_reg == '0) ? MD_IDLE : MD_DBL;
            default: state_next = MD_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= last_step;
        end
    end

    // Datapath: remainder, quotient, multiplier bits
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    r_reg    <= '0;
                    q_reg    <= '0;
                    mult_reg <= mult;
                    num_reg  <= num;
                    den_reg  <= den;
                    cnt_reg  <= CNT_W'(MW - 1);
                end
            end
            MD_DBL: begin
                r_reg <= r_res;
                q_reg <= {q_reg[MW-2:0], wrap};
            end
            MD_ADD: begin
                if (mult_reg[MW-1]) begin
                    r_reg <= r_res;
                    q_reg <= q_reg + MW'(wrap);
                end
                mult_reg <= mult_reg << 1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for pwm_duty_angle_decoder_top: edge transfers in, positions out.
// Carries its own edge tracker and exact multiply-divide to predict every result.
// Depends on rtl/pdad_pkg.sv and rtl/pwm_duty_angle_decoder_top.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdad_pkg::*;

    localparam int  FRAC_BITS   = FRACTION_BITS_DEF;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  SETTLE_CYC  = 60;      // covers one measured falling edge

    localparam logic EDGE_FALL = 1'b0;
    localparam logic EDGE_RISE = 1'b1;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [TICKS_W-1:0] period;
        logic [TICKS_W-1:0] high;
        logic [POS_W-1:0]   position;
    } pos_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // [31:0] timestamp
    logic                 s_tuser   = 1'b0; // [0] kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [19:0] position, [51:20] high, [83:52] period
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // predictor copy of registers and edge state
    logic [CFG_W-1:0] full_scale   = FULL_SCALE_RST;
    logic [CFG_W-1:0] offset_cfg   = OFFSET_RST;
    logic [CFG_W-1:0] counts_cfg   = COUNTS_RST;
    logic [31:0]      rise_time    = '0;
    logic [31:0]      period_len   = '0;
    logic             rise_seen    = 1'b0;

    pos_result_t pending_positions[$];

    int errors      = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    bit tx_gaps     = 1'b0;
    int rx_mode     = 0;
    int stall_left  = 0;

    pwm_duty_angle_decoder_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Edge tracker plus exact floor(fs*16*high/period); product stays below 2^52.
    function automatic bit decode_edge(input logic kind, input logic [31:0] ts,
                                       output pos_result_t res);
        logic [31:0] high;
        logic [63:0] quot;
        logic [63:0] base;
        logic [63:0] top_limit;
        logic [63:0] pos;
        decode_edge = 1'b0;
        res = '0;
        if (kind == EDGE_RISE) begin
            if (rise_seen)
                period_len = ts - rise_time;
            rise_time = ts;
            rise_seen = 1'b1;
        end else if (rise_seen) begin
            high = ts - rise_time;
            if (period_len != 0 && high <= period_len) begin
                quot      = ((64'(full_scale) << FRAC_BITS) * 64'(high)) / 64'(period_len);
                base      = 64'(offset_cfg) << FRAC_BITS;
                top_limit = 64'(counts_cfg) << FRAC_BITS;
                pos = (quot > base) ? quot - base : 64'd0;
                if (pos > top_limit)
                    pos = top_limit;
                if (pos > 64'(POS_MAX))
                    pos = 64'(POS_MAX);
                res.position = pos[POS_W-1:0];
                res.high     = high;
                res.period   = period_len;
                decode_edge  = 1'b1;
            end
        end
    endfunction

    // Result side: check each transfer, then pick next m_tready from the stall pattern.
    always @(posedge aclk) begin : result_monitor
        pos_result_t got;
        pos_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_BITS-1:0];
            if (pending_positions.size() == 0) begin
                $error("unexpected result: position %0d high %0d period %0d",
                       got.position, got.high, got.period);
                errors++;
            end else begin
                want = pending_positions.pop_front();
                if (got.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    errors++;
                end
                if (got.high !== want.high) begin
                    $error("high_ticks: expected %0d, got %0d", want.high, got.high);
                    errors++;
                end
                if (got.period !== want.period) begin
                    $error("period_ticks_out: expected %0d, got %0d", want.period, got.period);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(1, 40);
                    m_tready <= (stall_left == 0);
                end
            endcase
        end
    end

    // One edge transfer; optional gap between bursts, prediction on acceptance.
    task automatic send_edge(input logic kind, input logic [31:0] ts);
        pos_result_t res;
        if (tx_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ts;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (decode_edge(kind, ts, res))
            pending_positions.push_back(res);
    endtask

    // Hold off input until every result is back and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FULL_SCALE: full_scale = val;
            REG_OFFSET:     offset_cfg = val;
            REG_COUNTS:     counts_cfg = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_W-1:0] fs, input logic [CFG_W-1:0] off,
                               input logic [CFG_W-1:0] cnt);
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_OFFSET, off);
        write_reg(REG_COUNTS, cnt);
        cfg_wr_en <= 1'b0;
    endtask

    // Rise one period after the last rise, then a few falls inside (mostly) that period.
    task automatic send_frame();
        logic [31:0] per;
        logic [31:0] rise_at;
        logic [31:0] hi;
        int n_falls;
        case ($urandom_range(0, 3))
            0: per = $urandom_range(1, 64);
            1: per = $urandom_range(65, 65535);
            2: per = $urandom_range(65536, 32'h00FF_FFFF);
            default: per = $urandom();
        endcase
        rise_at = rise_time + per;
        send_edge(EDGE_RISE, rise_at);
        n_falls = $urandom_range(0, 3);
        repeat (n_falls) begin
            case ($urandom_range(0, 9))
                0: hi = '0;
                1: hi = per;
                2: hi = per + $urandom_range(1, 1000);   // longer than the period
                default: hi = $urandom_range(0, per);
            endcase
            send_edge(EDGE_FALL, rise_at + hi);
        end
    endtask

    // Edge cases under reset configuration
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_mode = 0;
        send_edge(EDGE_FALL, 32'd100);          // no rise yet
        send_edge(EDGE_RISE, 32'd1000);
        send_edge(EDGE_FALL, 32'd1100);         // period still unknown
        send_edge(EDGE_RISE, 32'd2000);
        send_edge(EDGE_FALL, 32'd2000);         // zero high time
        send_edge(EDGE_FALL, 32'd2500);
        send_edge(EDGE_FALL, 32'd3000);         // high equals period, clamps
        send_edge(EDGE_FALL, 32'd3001);         // high past period
        send_edge(EDGE_RISE, 32'd3000);
        send_edge(EDGE_RISE, 32'd3000);         // zero period
        send_edge(EDGE_FALL, 32'd3000);
        send_edge(EDGE_RISE, 32'hFFFF_FF00);
        send_edge(EDGE_RISE, 32'h0000_0100);    // period across the wrap
        send_edge(EDGE_FALL, 32'h0000_0180);
        send_edge(EDGE_FALL, 32'h0000_0000);    // huge high, dropped
        send_edge(EDGE_RISE, 32'hFFFF_FFFF);
        send_edge(EDGE_RISE, 32'hFFFF_FFFE);    // full-range period
        send_edge(EDGE_FALL, 32'hFFFF_FFFD);
        send_edge(EDGE_FALL, 32'h7FFF_FFFE);
        send_edge(EDGE_FALL, 32'h0000_0000);
        // period of 16448*16 ticks: quotient equals high, probe the offset edge
        send_edge(EDGE_RISE, 32'h0000_1000);
        send_edge(EDGE_RISE, 32'h0000_1000 + 32'd263168);
        send_edge(EDGE_FALL, 32'h0000_1000 + 32'd263168 + 32'd512);
        send_edge(EDGE_FALL, 32'h0000_1000 + 32'd263168 + 32'd513);
        wait_idle();
    endtask

    // Register extremes, zero scale and zero clamp, and a write to an unused index
    task automatic test_config_extremes();
        logic [CFG_W-1:0] cfg_sets[6][3];
        cfg_sets = '{'{16'd1, 16'd0, 16'd1},
                     '{16'd65535, 16'd0, 16'd65535},
                     '{16'd65535, 16'd65535, 16'd65535},
                     '{16'd16448, 16'd65535, 16'd1},
                     '{16'd0, 16'd0, 16'd16384},
                     '{16'd16448, 16'd32, 16'd0}};
        for (int c = 0; c < 6; c++) begin
            if (c == 2)
                write_reg(REG_UNUSED, 16'hFFFF);
            load_config(cfg_sets[c][0], cfg_sets[c][1], cfg_sets[c][2]);
            tx_gaps = c[0];
            rx_mode = c % 3;
            repeat (8) send_frame();
            wait_idle();
        end
    endtask

    // Random configurations, mostly well-formed frames with some stray edges
    task automatic test_random_frames(input int phases, input int items_per_phase);
        int stop_at;
        logic [CFG_W-1:0] fs;
        for (int p = 0; p < phases; p++) begin
            fs = CFG_W'($urandom_range(1, 65535));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                load_config(FULL_SCALE_RST, OFFSET_RST, COUNTS_RST);
            else
                load_config(fs, CFG_W'($urandom_range(0, fs / 4)),
                            CFG_W'($urandom_range(1, 65535)));
            tx_gaps = (p % 3 != 0);
            rx_mode = $urandom_range(0, 2);
            stop_at = items_sent + items_per_phase;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 6) == 0)
                    send_edge(1'($urandom_range(0, 1)), $urandom());
                else
                    send_frame();
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random_frames(7, 230);
        wait_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
